// ===== rtl/fmt02_pkg.sv =====
// ----------------------------------------------------------------------------
// fmt02_pkg
// Shared types and constants for the two-byte BCD/decimal-exponent codec.
// ----------------------------------------------------------------------------
package fmt02_pkg;

	localparam int NCELL = 12;              // rounding divide-by-ten cells

	localparam logic [31:0] MAG_LIMIT   = 32'd1000;
	localparam logic [31:0] ROUND_ADD   = 32'd5;
	localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;   // (x * m) >> 35 == x / 10
	localparam logic [31:0] DIV1000_MUL = 32'h1062_4DD3;   // (x * m) >> 38 == x / 1000
	localparam logic [7:0]  EXP_TOP     = 8'd7;            // largest code that fits 3 bits
	localparam logic [3:0]  BCD_MAX     = 4'd9;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	// item as it travels down the row of cells
	typedef struct packed {
		logic        cmd;
		logic        neg;
		logic [7:0]  expo;
		logic [31:0] mag;
		logic [7:0]  code_lo;
		logic [7:0]  code_hi;
	} cell_t;

	// 10^(8-code)
	function automatic logic [26:0] scale_of(input logic [2:0] code);
		logic [26:0] s;
		case (code)
			3'd0:    s = 27'd100000000;
			3'd1:    s = 27'd10000000;
			3'd2:    s = 27'd1000000;
			3'd3:    s = 27'd100000;
			3'd4:    s = 27'd10000;
			3'd5:    s = 27'd1000;
			3'd6:    s = 27'd100;
			3'd7:    s = 27'd10;
			default: s = 27'd10;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/fmt02_div_cell.sv =====
// ----------------------------------------------------------------------------
// fmt02_div_cell
// One step of the encode loop: rounding divide by ten and exponent decrement.
// ----------------------------------------------------------------------------
module fmt02_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              vld_i,
	input  fmt02_pkg::cell_t  d_i,
	output logic              vld_o,
	output fmt02_pkg::cell_t  d_o
);
	import fmt02_pkg::*;

	logic        busy;
	logic [31:0] sum;
	logic [63:0] prod;
	cell_t       nxt;
	cell_t       d_q;
	logic        vld_q;

	assign busy = (d_i.cmd == CMD_ENCODE) && (d_i.expo != 8'd0)
		&& ((|d_i.expo[7:3]) || (d_i.mag >= MAG_LIMIT));
	assign sum  = d_i.mag + ROUND_ADD;          // magnitude never exceeds 2^31
	assign prod = 64'(sum) * 64'(DIV10_MUL);

	always_comb begin
		nxt = d_i;
		if (busy) begin
			if (d_i.mag == 32'd0) begin
				// zero stays zero: skip straight down to the top 3-bit code
				nxt.expo = EXP_TOP;
			end else begin
				nxt.expo = d_i.expo - 8'd1;
				nxt.mag  = 32'(prod[63:35]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_q <= nxt;
		end
	end

	assign vld_o = vld_q;
	assign d_o   = d_q;

endmodule

// ===== rtl/fmt02_pack.sv =====
// ----------------------------------------------------------------------------
// fmt02_pack
// Packs encode results into BCD code bytes and rebuilds decoded values.
// ----------------------------------------------------------------------------
module fmt02_pack (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              vld_i,
	input  fmt02_pkg::cell_t  d_i,
	output logic              vld_o,
	output logic [7:0]        code_low,
	output logic [7:0]        code_high,
	output logic signed [38:0] value,
	output logic              res_ok,
	output logic              ovf
);
	import fmt02_pkg::*;

	// stage 1: divide by 1000, digit sum and scale
	logic [63:0] q_prod;
	logic [3:0]  d_units, d_tens, d_hund;
	logic        vld_s1, cmd_s1, neg_s1, ovf_s1, ok_s1;
	logic [2:0]  e3_s1;
	logic [31:0] mag_s1;
	logic [21:0] q1k_s1;
	logic [10:0] dsum_s1;
	logic [26:0] scale_s1;

	// stage 2: remainder mod 1000, decoded product
	logic [31:0] rem_full;
	logic        vld_s2, cmd_s2, neg_s2, ovf_s2, ok_s2;
	logic [2:0]  e3_s2;
	logic [9:0]  rem_s2;
	logic [37:0] prod_s2;

	// stage 3: hundreds digit, signed value
	logic [15:0] h_prod;
	logic [3:0]  hund;
	logic [9:0]  r2_full;
	logic        vld_s3, cmd_s3, neg_s3, ovf_s3, ok_s3;
	logic [2:0]  e3_s3;
	logic [3:0]  hund_s3;
	logic [6:0]  r2_s3;
	logic signed [38:0] val_s3;

	// output register
	logic [14:0] t_prod;
	logic [3:0]  tens, units;
	logic [6:0]  u_full;
	logic        vld_q, ok_q, ovf_q;
	logic [7:0]  lo_q, hi_q;
	logic signed [38:0] val_q;

	assign q_prod  = 64'(d_i.mag) * 64'(DIV1000_MUL);
	assign d_units = d_i.code_lo[3:0];
	assign d_tens  = d_i.code_lo[7:4];
	assign d_hund  = d_i.code_hi[3:0];

	assign rem_full = mag_s1 - 32'(q1k_s1) * 32'd1000;

	assign h_prod  = 16'(rem_s2) * 16'd41;
	assign hund    = h_prod[15:12];
	assign r2_full = rem_s2 - 10'(hund) * 10'd100;

	assign t_prod = 15'(r2_s3) * 15'd205;
	assign tens   = t_prod[14:11];
	assign u_full = r2_s3 - 7'(tens) * 7'd10;
	assign units  = u_full[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_q  <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1   <= d_i.cmd;
			neg_s1   <= (d_i.cmd == CMD_ENCODE) ? d_i.neg : d_i.code_hi[4];
			e3_s1    <= d_i.expo[2:0];
			ovf_s1   <= d_i.mag >= MAG_LIMIT;
			mag_s1   <= d_i.mag;
			q1k_s1   <= q_prod[59:38];
			ok_s1    <= (d_units <= BCD_MAX) && (d_tens <= BCD_MAX);
			dsum_s1  <= 11'(d_units) + 11'(d_tens) * 11'd10 + 11'(d_hund) * 11'd100;
			scale_s1 <= scale_of(d_i.code_hi[7:5]);

			cmd_s2  <= cmd_s1;
			neg_s2  <= neg_s1;
			e3_s2   <= e3_s1;
			ovf_s2  <= ovf_s1;
			ok_s2   <= ok_s1;
			rem_s2  <= rem_full[9:0];
			prod_s2 <= 38'(dsum_s1) * 38'(scale_s1);

			cmd_s3  <= cmd_s2;
			neg_s3  <= neg_s2;
			e3_s3   <= e3_s2;
			ovf_s3  <= ovf_s2;
			ok_s3   <= ok_s2;
			hund_s3 <= hund;
			r2_s3   <= r2_full[6:0];
			if (!ok_s2) begin
				val_s3 <= '0;
			end else if (neg_s2) begin
				val_s3 <= -$signed({1'b0, prod_s2});
			end else begin
				val_s3 <= $signed({1'b0, prod_s2});
			end

			if (cmd_s3 == CMD_ENCODE) begin
				lo_q  <= {tens, units};
				hi_q  <= {e3_s3, neg_s3, hund_s3};
				val_q <= '0;
				ok_q  <= 1'b1;
				ovf_q <= ovf_s3;
			end else begin
				lo_q  <= '0;
				hi_q  <= '0;
				val_q <= val_s3;
				ok_q  <= ok_s3;
				ovf_q <= 1'b0;
			end
		end
	end

	assign vld_o     = vld_q;
	assign code_low  = lo_q;
	assign code_high = hi_q;
	assign value     = val_q;
	assign res_ok    = ok_q;
	assign ovf       = ovf_q;

endmodule

// ===== rtl/fmt02_bcd_float_codec_core.sv =====
// ----------------------------------------------------------------------------
// fmt02_bcd_float_codec_core
// Encoder/decoder for the two-byte meter number format: three BCD digits,
// sign flag and a 3-bit decimal exponent code.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | cmd, in_value, start_exponent,
//          |                      | in_code_low, in_code_high
//  out     | out_valid / out_ready| out_code_low, out_code_high, out_value,
//          |                      | valid_res, overflow
//
//  Each beat passes 12 divide-by-ten cells in a row, then three packing
//  stages and the output register. The row moves one cell per cycle, so a new
//  beat can follow every cycle while the output is taken.
//  While the output register holds a beat that is not taken, the whole row
//  and the packing stages freeze and in_ready is low.
//  Reset clears only the valid flags; no clearing pass is needed.
//
//  Encode: the sign is stripped at the entry, each cell does at most one
//  rounding divide by ten (or jumps a zero magnitude straight to code 7),
//  the packing stages split what is left into BCD digits.
//  Decode: the cells pass the code bytes through untouched; the packing
//  stages check the low byte for BCD and scale the digits by 10^(8-code).
// ----------------------------------------------------------------------------
module fmt02_bcd_float_codec_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic signed [31:0] in_value,
	input  logic [7:0]         start_exponent,
	input  logic [7:0]         in_code_low,
	input  logic [7:0]         in_code_high,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_code_low,
	output logic [7:0]         out_code_high,
	output logic signed [38:0] out_value,
	output logic               valid_res,
	output logic               overflow
);
	import fmt02_pkg::*;

	logic  adv;
	logic  cell_v [0:NCELL];
	cell_t cell_d [0:NCELL];

	// whole datapath advances together unless the output beat is stuck
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// entry: sign and magnitude; -2^31 gives 2^31, exact in 32 unsigned bits
	always_comb begin
		cell_d[0].cmd     = cmd;
		cell_d[0].neg     = in_value[31];
		cell_d[0].expo    = start_exponent;
		cell_d[0].mag     = in_value[31] ? (32'd0 - 32'(in_value)) : 32'(in_value);
		cell_d[0].code_lo = in_code_low;
		cell_d[0].code_hi = in_code_high;
	end
	assign cell_v[0] = in_valid;

	// row of rounding divide cells; ten steps take any 32-bit magnitude to
	// zero, one more settles the exponent code
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		fmt02_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vld_i  (cell_v[i]),
			.d_i    (cell_d[i]),
			.vld_o  (cell_v[i+1]),
			.d_o    (cell_d[i+1])
		);
	end

	fmt02_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.vld_i     (cell_v[NCELL]),
		.d_i       (cell_d[NCELL]),
		.vld_o     (out_valid),
		.code_low  (out_code_low),
		.code_high (out_code_high),
		.value     (out_value),
		.res_ok    (valid_res),
		.ovf       (overflow)
	);

endmodule
